[hdl/rsn_pkg.sv]
// Shared types, constants and helper functions for the recurrent sigmoid network step.
// Used by rsn_cell, rsn_sigmoid and recurrent_sigmoid_network_step; depends on nothing.
package rsn_pkg;

    localparam int IDX_W  = 6;     // width of neuron index fields
    localparam int VAL_W  = 16;    // Q8.8 weights and thresholds
    localparam int ACT_W  = 16;    // Q1.15 activations
    localparam int MODE_W = 2;
    localparam int W_ENTRY_W = VAL_W + 1;  // weight plus connection mark

    localparam int NEURONS_DEFAULT = 64;

    localparam logic [MODE_W-1:0] MODE_WEIGHT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_THRESHOLD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEP      = 2'd2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = IDX_W;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND = 1'd1;
    localparam logic [IDX_W-1:0] FIRST_RESET  = 6'd0;
    localparam logic [IDX_W-1:0] SECOND_RESET = 6'd53;

    // Accumulator covers up to 256 products of 31 significant bits.
    localparam int ACC_W = 40;
    localparam int D_W   = ACC_W + 1;

    localparam logic [ACT_W-1:0] ONE_Q15 = 16'd32768;
    localparam logic [15:0] GAIN_Q16  = 16'd64225;   // 0.98
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;   // log2(e)
    localparam logic [27:0] ARG_LIMIT = 28'd134217728; // 16 in Q.23
    localparam logic [19:0] DIV10_MAGIC = 20'd838861;  // ceil(2^23 / 10)
    localparam int DIV10_SHIFT = 23;

    typedef struct packed {
        logic rotate;
        logic push;
        logic commit;
    } cell_ctl_t;

    function automatic logic [ACT_W-1:0] clamp_act(input logic [ACT_W-1:0] v);
        clamp_act = (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

    // 2^(-k/16) in Q16 for k = 0..16.
    function automatic logic [16:0] pow2_neg(input logic [4:0] k);
        logic [16:0] r;
        unique case (k)
            5'd0:    r = 17'd65536;
            5'd1:    r = 17'd62757;
            5'd2:    r = 17'd60097;
            5'd3:    r = 17'd57549;
            5'd4:    r = 17'd55109;
            5'd5:    r = 17'd52773;
            5'd6:    r = 17'd50535;
            5'd7:    r = 17'd48393;
            5'd8:    r = 17'd46341;
            5'd9:    r = 17'd44376;
            5'd10:   r = 17'd42495;
            5'd11:   r = 17'd40693;
            5'd12:   r = 17'd38968;
            5'd13:   r = 17'd37316;
            5'd14:   r = 17'd35734;
            5'd15:   r = 17'd34219;
            5'd16:   r = 17'd32768;
            default: r = 17'd0;
        endcase
        pow2_neg = r;
    endfunction

endpackage

[hdl/rsn_cell.sv]
// One cell of the activation chain: the current and the pending activation of one neuron.
// Depends on rsn_pkg.
module rsn_cell
    import rsn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic             force_en,
    input  logic [ACT_W-1:0] force_val,
    input  logic [ACT_W-1:0] act_in,
    input  logic [ACT_W-1:0] nxt_in,
    output logic [ACT_W-1:0] act,
    output logic [ACT_W-1:0] nxt
);

    logic [ACT_W-1:0] act_reg;
    logic [ACT_W-1:0] nxt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= '0;
        end
        else if (force_en)
        begin
            act_reg <= force_val;
        end
        else if (ctl.rotate)
        begin
            act_reg <= act_in;
        end
        else if (ctl.commit)
        begin
            act_reg <= nxt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            nxt_reg <= nxt_in;
        end
    end

    assign act = act_reg;
    assign nxt = nxt_reg;

endmodule

[hdl/rsn_sigmoid.sv]
// Multi-cycle fixed-point sigmoid: gain, saturation, exp2 interpolation and a restoring divider.
// Depends on rsn_pkg for widths, constants and the 2^(-k/16) table.
module rsn_sigmoid
    import rsn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [D_W-1:0] d,
    output logic                  done,
    output logic [ACT_W-1:0]      s
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_INTP = 3'd3;
    localparam logic [2:0] ST_EXP  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic [4:0]      cnt_reg;
    logic            neg_reg;
    logic [D_W-1:0]  mag_reg;
    logic [27:0]     m_reg;
    logic [21:0]     t_reg;
    logic [16:0]     tk_reg;
    logic [23:0]     ip_reg;
    logic [5:0]      n_reg;
    logic [17:0]     den_reg;
    logic [17:0]     rem_reg;
    logic [15:0]     numlo_reg;
    logic [15:0]     q_reg;

    logic [43:0] m_prod;
    logic [27:0] m_sh;
    logic [27:0] m_next;
    logic [37:0] t_prod;
    logic [16:0] tk;
    logic [16:0] tk1;
    logic [11:0] diff;
    logic [16:0] p;
    logic [16:0] e;
    logic [17:0] den;
    logic [18:0] rem2;
    logic        ge;

    always_comb
    begin
        m_prod = 44'(mag_reg[27:0]) * 44'(GAIN_Q16);
        m_sh   = m_prod[43:16];
        m_next = ((|mag_reg[D_W-1:28]) || (m_sh > ARG_LIMIT)) ? ARG_LIMIT : m_sh;
        t_prod = 38'(m_reg[27:7]) * 38'(LOG2E_Q16);
        tk     = pow2_neg({1'b0, t_reg[15:12]});
        tk1    = pow2_neg(5'({1'b0, t_reg[15:12]}) + 5'd1);
        diff   = 12'(tk - tk1);
        p      = tk_reg - 17'(ip_reg >> 12);
        e      = p >> n_reg;
        den    = 18'd65536 + 18'(e);
        rem2   = {rem_reg, numlo_reg[15]};
        ge     = rem2 >= {1'b0, den_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_INTP;
            ST_INTP: state_next = ST_EXP;
            ST_EXP:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 5'd1) state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                neg_reg <= d[D_W-1];
                mag_reg <= d[D_W-1] ? D_W'(-d) : D_W'(d);
            end
            ST_MUL1: m_reg <= m_next;
            ST_MUL2: t_reg <= t_prod[37:16];
            ST_INTP:
            begin
                tk_reg <= tk;
                ip_reg <= 24'(diff) * 24'(t_reg[11:0]);
                n_reg  <= t_reg[21:16];
            end
            ST_EXP:
            begin
                // Dividend is 2^31 + den/2; its upper half is already below den.
                den_reg   <= den;
                rem_reg   <= 18'd32768 + 18'(den[17]);
                numlo_reg <= den[16:1];
                cnt_reg   <= 5'd16;
            end
            ST_DIV:
            begin
                rem_reg   <= ge ? 18'(rem2 - {1'b0, den_reg}) : 18'(rem2);
                numlo_reg <= {numlo_reg[14:0], 1'b0};
                q_reg     <= {q_reg[14:0], ge};
                cnt_reg   <= cnt_reg - 5'd1;
            end
            default: ;
        endcase
    end

    // The quotient is final while done is high, so s is read in that cycle.
    assign done = (state_reg == ST_OUT);
    assign s    = neg_reg ? ONE_Q15 - q_reg : q_reg;

endmodule

[hdl/recurrent_sigmoid_network_step.sv]
// Recurrent sigmoid network step: top level with weight and threshold stores and the MAC loop.
// Depends on rsn_pkg, rsn_cell and rsn_sigmoid.
//
// A step beat makes the block compute every neuron's net input as a weighted sum of the old
// activations, pass it through a sigmoid and blend 0.9 of it with 0.1 of the old activation,
// then deliver one result beat per neuron in index order with last set on the final one.
// Activations live in a ring of cells that rotates once per neuron, feeding one multiply and
// accumulate per cycle while the weight memory streams out that neuron's row; the new values
// collect in a second chain and replace the old ones once the whole step is through. Each
// neuron passes through the row sweep, the pipeline drain, the sigmoid unit with its divider
// and the blend, and the emission of its beat, which any output stall holds; a step also
// includes its accepting and its commit cycle. After reset the block clears the weight and
// threshold memories, during which it stalls its input; configuration writes are taken at
// any time.
module recurrent_sigmoid_network_step
    import rsn_pkg::*;
#(
    parameter int NEURONS = NEURONS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [MODE_W-1:0]       mode,
    input  logic [IDX_W-1:0]        target_neuron,
    input  logic [IDX_W-1:0]        source_neuron,
    input  logic signed [VAL_W-1:0] load_value,
    input  logic                    is_connected,
    input  logic [ACT_W-1:0]        ext_first,
    input  logic [ACT_W-1:0]        ext_second,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [IDX_W-1:0]        neuron_index,
    output logic [ACT_W-1:0]        activation,
    output logic                    last
);

    localparam int NIDX  = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int DEPTH = NEURONS * NEURONS;
    localparam int AW    = $clog2(DEPTH);
    // Compare width wide enough for both the 6-bit fields and NEURONS itself.
    localparam int CW    = ((NIDX + 1) > IDX_W) ? (NIDX + 1) : (IDX_W + 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MAC    = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_SIG    = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;
    localparam logic [2:0] ST_COMMIT = 3'd6;

    // Configuration registers.
    logic [IDX_W-1:0] first_reg;
    logic [IDX_W-1:0] second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= FIRST_RESET;
            second_reg <= SECOND_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FIRST)
            begin
                first_reg <= cfg_data;
            end
            if (cfg_index == CFG_SECOND)
            begin
                second_reg <= cfg_data;
            end
        end
    end

    logic [2:0]      state_reg, state_next;
    logic [AW-1:0]   clr_addr_reg;
    logic [AW-1:0]   mac_addr_reg;
    logic [NIDX-1:0] i_reg;
    logic [NIDX-1:0] j_reg;
    logic            in_acc;
    logic            out_acc;
    logic            i_last;
    logic            j_last;
    logic            v1_reg, v2_reg;
    logic            sig_start;
    logic            sig_done;
    logic [ACT_W-1:0] sig_s;

    assign in_acc  = in_valid && (state_reg == ST_IDLE);
    assign out_acc = (state_reg == ST_EMIT) && !out_stall;
    assign i_last  = (i_reg == NIDX'(NEURONS - 1));
    assign j_last  = (j_reg == NIDX'(NEURONS - 1));

    // Write decoding of an accepted beat; out-of-range indices are dropped.
    logic tgt_ok, src_ok;
    logic w_we, t_we;
    logic [AW-1:0]   w_waddr;
    logic [NIDX-1:0] t_waddr;
    assign tgt_ok  = CW'(target_neuron) < CW'(NEURONS);
    assign src_ok  = CW'(source_neuron) < CW'(NEURONS);
    assign w_we    = in_acc && (mode == MODE_WEIGHT) && tgt_ok && src_ok;
    assign t_we    = in_acc && (mode == MODE_THRESHOLD) && tgt_ok;
    assign w_waddr = AW'(int'(NIDX'(target_neuron)) * NEURONS + int'(NIDX'(source_neuron)));
    assign t_waddr = NIDX'(target_neuron);

    // Weight memory: one write port shared by the clearing sweep, one registered read port.
    logic [W_ENTRY_W-1:0] wmem [DEPTH];
    logic [W_ENTRY_W-1:0] w_rd_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            wmem[clr_addr_reg] <= '0;
        end
        else if (w_we)
        begin
            wmem[w_waddr] <= {is_connected, load_value};
        end
        w_rd_reg <= wmem[mac_addr_reg];
    end

    // Threshold memory, cleared during the sweep while the clearing address is below NEURONS.
    logic [VAL_W-1:0] tmem [NEURONS];
    logic [VAL_W-1:0] thr_rd_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            if (clr_addr_reg < AW'(NEURONS))
            begin
                tmem[NIDX'(clr_addr_reg)] <= '0;
            end
        end
        else if (t_we)
        begin
            tmem[t_waddr] <= load_value;
        end
        thr_rd_reg <= tmem[i_reg];
    end

    // Activation chain. Cell 0 is the head of the ring; new values enter at the far end.
    cell_ctl_t        cell_ctl;
    logic [ACT_W-1:0] acts [NEURONS];
    logic [ACT_W-1:0] nxts [NEURONS];
    logic [ACT_W-1:0] nv_reg;
    logic             step_acc;

    assign step_acc        = in_acc && (mode == MODE_STEP);
    assign cell_ctl.rotate = (state_reg == ST_MAC);
    assign cell_ctl.push   = out_acc;
    assign cell_ctl.commit = (state_reg == ST_COMMIT);

    genvar k;
    generate
        for (k = 0; k < NEURONS; k++)
        begin : g_cell
            logic sel_first, sel_second;
            assign sel_first  = (CW'(first_reg) == CW'(k));
            assign sel_second = (CW'(second_reg) == CW'(k));

            rsn_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (cell_ctl),
                .force_en  (step_acc && (sel_first || sel_second)),
                .force_val (sel_second ? clamp_act(ext_second) : clamp_act(ext_first)),
                .act_in    (acts[(k + 1) % NEURONS]),
                .nxt_in    ((k == NEURONS - 1) ? nv_reg : nxts[(k + 1) % NEURONS]),
                .act       (acts[k]),
                .nxt       (nxts[k])
            );
        end
    endgenerate

    // Multiply and accumulate pipeline: read/align, multiply, accumulate.
    logic [ACT_W-1:0]        act_d1_reg;
    logic [NIDX-1:0]         j_d1_reg;
    logic signed [31:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [ACT_W-1:0]        old_reg;
    logic signed [D_W-1:0]   d_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= (state_reg == ST_MAC);
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        act_d1_reg <= acts[0];
        j_d1_reg   <= j_reg;
        if (v1_reg)
        begin
            prod_reg <= w_rd_reg[W_ENTRY_W-1]
                ? signed'(w_rd_reg[VAL_W-1:0]) * signed'({16'd0, act_d1_reg})
                : 32'sd0;
            if (j_d1_reg == i_reg)
            begin
                old_reg <= clamp_act(act_d1_reg);
            end
        end
        if (step_acc || out_acc)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign d_val     = D_W'(acc_reg) - (D_W'(signed'(thr_rd_reg)) <<< 15);
    assign sig_start = (state_reg == ST_DRAIN) && !v1_reg && !v2_reg;

    rsn_sigmoid u_sigmoid (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sig_start),
        .d     (d_val),
        .done  (sig_done),
        .s     (sig_s)
    );

    // Blend: floor((9*s + old + 5) / 10), the division by a reciprocal multiply.
    logic [18:0] blend_sum;
    logic [38:0] blend_prod;
    assign blend_sum  = 19'({sig_s, 3'b000}) + 19'(sig_s) + 19'(old_reg) + 19'd5;
    assign blend_prod = 39'(blend_sum) * 39'(DIV10_MAGIC);

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SIG) && sig_done)
        begin
            nv_reg <= ACT_W'(blend_prod >> DIV10_SHIFT);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_addr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (step_acc) state_next = ST_MAC;
            ST_MAC:    if (j_last) state_next = ST_DRAIN;
            ST_DRAIN:  if (sig_start) state_next = ST_SIG;
            ST_SIG:    if (sig_done) state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    state_next = i_last ? ST_COMMIT : ST_MAC;
                end
            end
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            mac_addr_reg <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (step_acc)
            begin
                mac_addr_reg <= '0;
                i_reg        <= '0;
                j_reg        <= '0;
            end
            else if (state_reg == ST_MAC)
            begin
                mac_addr_reg <= mac_addr_reg + AW'(1);
                j_reg        <= j_last ? '0 : j_reg + NIDX'(1);
            end
            else if (out_acc && !i_last)
            begin
                i_reg <= i_reg + NIDX'(1);
            end
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = (state_reg == ST_EMIT);
    assign neuron_index = IDX_W'(i_reg);
    assign activation   = nv_reg;
    assign last         = i_last;

endmodule
